/* rtl/core/klock_pkg.sv */
// shared types, constants and helpers of the keypad code lock
`timescale 1ns / 1ps

package klock_pkg;

	localparam int CODE_DIGITS = 6;
	// key codes stored per 24-bit code register
	localparam int CODE_NIBBLES = 6;
	localparam int CODE_W = 4 * CODE_NIBBLES;
	localparam int DIGIT_W = $clog2(CODE_DIGITS + 1);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [3:0] TRIES_SAT = 4'd15;

	typedef enum logic [1:0] {
		REQ_KEY     = 2'd0,
		REQ_TIMEOUT = 2'd1,
		REQ_RESTART = 2'd2,
		REQ_NONE    = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		CMD_KEY,
		CMD_TIMEOUT,
		CMD_RESTART,
		CMD_NOP
	} cmd_kind_t;

	typedef enum logic [2:0] {
		ST_DIGIT     = 3'd0,
		ST_RETRY     = 3'd1,
		ST_LOCKED    = 3'd2,
		ST_UNLOCKED  = 3'd3,
		ST_RECOVERED = 3'd4,
		ST_WRONG_REC = 3'd5,
		ST_TIMEOUT   = 3'd6,
		ST_IGNORED   = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		CFG_LOCK_CODE    = 2'd0,
		CFG_RECOVERY     = 2'd1,
		CFG_MAX_ATTEMPTS = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [3:0] key;
		logic       puk;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	// key code expected at a given position; positions past the code read as zero
	function automatic logic [3:0] code_nibble(input logic [CODE_W-1:0] code,
			input logic [DIGIT_W-1:0] pos);
		logic [3:0] nib;
		nib = 4'd0;
		for (int i = 0; i < CODE_NIBBLES; i++) begin
			if (i < CODE_DIGITS && pos == DIGIT_W'(i)) begin
				nib = code[i*4 +: 4];
			end
		end
		return nib;
	endfunction

endpackage

/* rtl/core/keypad_code_lock.sv */
// top level of the keypad code lock: config registers, front end, queue, back end
`timescale 1ns / 1ps

// Keypad combination lock. Each input word is a key press, a timeout or a session
// restart and yields exactly one result word with status, digits collected, tries
// left and the session outcome flags. An attempt is six keys; the code is judged
// only after the last key, and the attempt's mode (user or recovery code) is taken
// from puk_mode at its first key. The block takes one word per cycle while in_stall
// is low: a word is classified and written into the queue when accepted, and once
// it is at the queue head and the result slot is free the back end pops it and
// registers its result word in the output registers, which present it. A two-entry
// queue lets input and output stall on their own. Configuration writes are always
// accepted (cfg_ready is high) and must be issued only while no word is in flight;
// index 3 writes nothing.
module keypad_code_lock import klock_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [3:0]  key_code,
	input  logic        puk_mode,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [2:0]  digits_entered,
	output logic [3:0]  tries_left,
	output logic        door_open,
	output logic        locked_out
);

	logic [CODE_W-1:0] lock_code_q;
	logic [CODE_W-1:0] recovery_code_q;
	logic [3:0]        max_attempts_q;

	queue_status_t     q_stat;
	logic              push;
	logic              pop;
	cmd_t              push_cmd;
	cmd_t              head_cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_code_q     <= 24'h000000;
			recovery_code_q <= 24'h111111;
			max_attempts_q  <= 4'd3;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_LOCK_CODE:    lock_code_q     <= cfg_data;
				CFG_RECOVERY:     recovery_code_q <= cfg_data;
				CFG_MAX_ATTEMPTS: max_attempts_q  <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	klock_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.req_type (req_type),
		.key_code (key_code),
		.puk_mode (puk_mode),
		.q_stat   (q_stat),
		.push     (push),
		.cmd      (push_cmd)
	);

	klock_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.q_stat   (q_stat)
	);

	klock_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_stat         (q_stat),
		.head_cmd       (head_cmd),
		.pop            (pop),
		.lock_code      (lock_code_q),
		.recovery_code  (recovery_code_q),
		.max_attempts   (max_attempts_q),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.digits_entered (digits_entered),
		.tries_left     (tries_left),
		.door_open      (door_open),
		.locked_out     (locked_out)
	);

endmodule

/* rtl/core/klock_front.sv */
// front end: takes input words and classifies them into lock commands
`timescale 1ns / 1ps

module klock_front import klock_pkg::*; (
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [1:0]    req_type,
	input  logic [3:0]    key_code,
	input  logic          puk_mode,
	input  queue_status_t q_stat,
	output logic          push,
	output cmd_t          cmd
);

	always_comb begin
		cmd.key = key_code;
		cmd.puk = puk_mode;
		unique case (req_t'(req_type))
			REQ_KEY:     cmd.kind = CMD_KEY;
			REQ_TIMEOUT: cmd.kind = CMD_TIMEOUT;
			REQ_RESTART: cmd.kind = CMD_RESTART;
			REQ_NONE:    cmd.kind = CMD_NOP;
			default:     cmd.kind = CMD_NOP;
		endcase
	end

	assign in_stall = q_stat.full;
	assign push = in_valid && !q_stat.full;

endmodule

/* rtl/core/klock_queue.sv */
// short command queue between front end and back end
`timescale 1ns / 1ps

module klock_queue import klock_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cmd_t          push_cmd,
	input  logic          pop,
	output cmd_t          head_cmd,
	output queue_status_t q_stat
);

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head_cmd     = entry_q[rd_ptr_q];
	assign q_stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);

endmodule

/* rtl/core/klock_back.sv */
// back end: session state machine and registered result word
`timescale 1ns / 1ps

module klock_back import klock_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  queue_status_t     q_stat,
	input  cmd_t              head_cmd,
	output logic              pop,
	input  logic [CODE_W-1:0] lock_code,
	input  logic [CODE_W-1:0] recovery_code,
	input  logic [3:0]        max_attempts,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        status,
	output logic [2:0]        digits_entered,
	output logic [3:0]        tries_left,
	output logic              door_open,
	output logic              locked_out
);

	typedef enum logic [1:0] {
		OUT_ACTIVE,
		OUT_OPEN,
		OUT_LOCKED,
		OUT_TIMEOUT
	} outcome_t;

	logic [DIGIT_W-1:0] digit_idx_q;
	logic               mismatch_q;
	logic               is_rec_q;
	logic [3:0]         wrong_q;
	outcome_t           outcome_q;

	logic               out_valid_q;
	status_t            status_q;
	logic [2:0]         digits_q;
	logic [3:0]         tries_q;
	logic               door_q;
	logic               locked_q;

	logic [DIGIT_W-1:0] idx_n;
	logic               mm_n;
	logic               rec_n;
	logic [3:0]         wrong_n;
	outcome_t           outcome_n;
	status_t            status_n;

	logic               rec;
	logic               mm;
	logic [CODE_W-1:0]  code_sel;
	logic [DIGIT_W:0]   idx_inc;
	logic [3:0]         tries_n;

	// result slot frees up when empty or being taken this cycle
	assign pop = !q_stat.empty && (!out_valid_q || !out_stall);

	always_comb begin
		idx_n     = digit_idx_q;
		mm_n      = mismatch_q;
		rec_n     = is_rec_q;
		wrong_n   = wrong_q;
		outcome_n = outcome_q;
		status_n  = ST_IGNORED;
		rec       = (digit_idx_q == '0) ? head_cmd.puk : is_rec_q;
		code_sel  = rec ? recovery_code : lock_code;
		mm        = mismatch_q || (head_cmd.key != code_nibble(code_sel, digit_idx_q));
		idx_inc   = {1'b0, digit_idx_q} + 1'b1;

		unique case (head_cmd.kind)
			CMD_RESTART: begin
				idx_n     = '0;
				mm_n      = 1'b0;
				rec_n     = 1'b0;
				wrong_n   = '0;
				outcome_n = OUT_ACTIVE;
			end
			CMD_KEY: begin
				if (outcome_q == OUT_ACTIVE) begin
					rec_n = rec;
					if (idx_inc < (DIGIT_W+1)'(CODE_DIGITS)) begin
						status_n = ST_DIGIT;
						idx_n    = idx_inc[DIGIT_W-1:0];
						mm_n     = mm;
					end else begin
						// full code in: judge it and start a fresh attempt
						idx_n = '0;
						mm_n  = 1'b0;
						priority if (rec && mm) begin
							status_n = ST_WRONG_REC;
						end else if (rec) begin
							status_n  = ST_RECOVERED;
							outcome_n = OUT_OPEN;
						end else if (mm) begin
							wrong_n = (wrong_q == TRIES_SAT) ? wrong_q : wrong_q + 1'b1;
							if (wrong_n >= max_attempts) begin
								status_n  = ST_LOCKED;
								outcome_n = OUT_LOCKED;
							end else begin
								status_n = ST_RETRY;
							end
						end else begin
							status_n  = ST_UNLOCKED;
							outcome_n = OUT_OPEN;
						end
					end
				end
			end
			CMD_TIMEOUT: begin
				// recovery attempts ride through timeouts
				if (outcome_q == OUT_ACTIVE && !rec) begin
					idx_n     = '0;
					mm_n      = 1'b0;
					outcome_n = OUT_TIMEOUT;
					status_n  = ST_TIMEOUT;
				end
			end
			CMD_NOP: begin
			end
			default: begin
			end
		endcase

		tries_n = (wrong_n >= max_attempts) ? 4'd0 : max_attempts - wrong_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_idx_q <= '0;
			mismatch_q  <= 1'b0;
			is_rec_q    <= 1'b0;
			wrong_q     <= '0;
			outcome_q   <= OUT_ACTIVE;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				digit_idx_q <= idx_n;
				mismatch_q  <= mm_n;
				is_rec_q    <= rec_n;
				wrong_q     <= wrong_n;
				outcome_q   <= outcome_n;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q <= status_n;
			digits_q <= 3'(idx_n);
			tries_q  <= tries_n;
			door_q   <= (outcome_n == OUT_OPEN);
			locked_q <= (outcome_n == OUT_LOCKED);
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign digits_entered = digits_q;
	assign tries_left     = tries_q;
	assign door_open      = door_q;
	assign locked_out     = locked_q;

endmodule

/* dv/keypad_code_lock_tb.sv */
// self-checking testbench of the keypad code lock: directed table, then random sessions
`timescale 1ns / 1ps

module keypad_code_lock_tb;
	import klock_pkg::*;

	typedef enum logic [1:0] {
		SES_ACTIVE,
		SES_OPEN,
		SES_LOCKED,
		SES_TIMEOUT
	} session_t;

	typedef struct packed {
		status_t    st;
		logic [2:0] digits;
		logic [3:0] tries;
		logic       door;
		logic       lockd;
	} lock_result_t;

	typedef struct packed {
		logic [1:0]   req;
		logic [3:0]   key;
		logic         puk;
		bit           typed;
		lock_result_t res;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [23:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  req_type;
	logic [3:0]  key_code;
	logic        puk_mode;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic [2:0]  digits_entered;
	logic [3:0]  tries_left;
	logic        door_open;
	logic        locked_out;

	keypad_code_lock uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.key_code(key_code),
		.puk_mode(puk_mode),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.digits_entered(digits_entered),
		.tries_left(tries_left),
		.door_open(door_open),
		.locked_out(locked_out)
	);

	// predicted lock state and register copies
	logic [23:0] cfg_user;
	logic [23:0] cfg_recovery;
	logic [3:0]  cfg_max;
	logic [2:0]  p_digits;
	logic        p_miss;
	logic        p_rec;
	logic [3:0]  p_wrong;
	session_t    p_outcome;

	lock_result_t pending[$];
	int           mismatches;
	bit           in_calm;
	bit           out_calm;

	// reset registers: user code 0, recovery 111111, three tries
	dir_row_t dir_rows [26] = '{
		'{REQ_KEY,     4'd0,  1'b0, 1'b1, '{ST_DIGIT,     3'd1, 4'd3, 1'b0, 1'b0}},
		'{REQ_NONE,    4'd9,  1'b1, 1'b1, '{ST_IGNORED,   3'd1, 4'd3, 1'b0, 1'b0}},
		'{REQ_KEY,     4'd0,  1'b1, 1'b0, '0},
		'{REQ_KEY,     4'd0,  1'b0, 1'b0, '0},
		'{REQ_KEY,     4'd0,  1'b1, 1'b0, '0},
		'{REQ_KEY,     4'd0,  1'b0, 1'b0, '0},
		'{REQ_KEY,     4'd0,  1'b0, 1'b1, '{ST_UNLOCKED,  3'd0, 4'd3, 1'b1, 1'b0}},
		'{REQ_KEY,     4'd10, 1'b0, 1'b1, '{ST_IGNORED,   3'd0, 4'd3, 1'b1, 1'b0}},
		'{REQ_TIMEOUT, 4'd0,  1'b0, 1'b1, '{ST_IGNORED,   3'd0, 4'd3, 1'b1, 1'b0}},
		'{REQ_RESTART, 4'd15, 1'b1, 1'b1, '{ST_IGNORED,   3'd0, 4'd3, 1'b0, 1'b0}},
		'{REQ_TIMEOUT, 4'd0,  1'b1, 1'b1, '{ST_IGNORED,   3'd0, 4'd3, 1'b0, 1'b0}},
		'{REQ_TIMEOUT, 4'd0,  1'b0, 1'b1, '{ST_TIMEOUT,   3'd0, 4'd3, 1'b0, 1'b0}},
		'{REQ_RESTART, 4'd0,  1'b0, 1'b1, '{ST_IGNORED,   3'd0, 4'd3, 1'b0, 1'b0}},
		'{REQ_KEY,     4'd0,  1'b0, 1'b0, '0},
		'{REQ_KEY,     4'd0,  1'b0, 1'b0, '0},
		'{REQ_KEY,     4'd0,  1'b0, 1'b0, '0},
		'{REQ_KEY,     4'd0,  1'b0, 1'b0, '0},
		'{REQ_KEY,     4'd0,  1'b0, 1'b0, '0},
		'{REQ_KEY,     4'd11, 1'b0, 1'b1, '{ST_RETRY,     3'd0, 4'd2, 1'b0, 1'b0}},
		'{REQ_KEY,     4'd1,  1'b1, 1'b0, '0},
		'{REQ_TIMEOUT, 4'd0,  1'b0, 1'b0, '0},
		'{REQ_KEY,     4'd1,  1'b0, 1'b0, '0},
		'{REQ_KEY,     4'd1,  1'b0, 1'b0, '0},
		'{REQ_KEY,     4'd1,  1'b0, 1'b0, '0},
		'{REQ_KEY,     4'd1,  1'b0, 1'b0, '0},
		'{REQ_KEY,     4'd1,  1'b0, 1'b1, '{ST_RECOVERED, 3'd0, 4'd2, 1'b1, 1'b0}}
	};

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("keypad_code_lock verification failed");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		mismatches++;
	endtask

	function automatic lock_result_t lock_predict(input logic [1:0] req, input logic [3:0] key,
			input logic puk);
		lock_result_t r;
		logic [23:0]  code;
		logic [3:0]   want;
		r.st = ST_IGNORED;
		if (req == REQ_RESTART) begin
			p_digits = '0;
			p_miss = 1'b0;
			p_rec = 1'b0;
			p_wrong = '0;
			p_outcome = SES_ACTIVE;
		end else if (req == REQ_KEY && p_outcome == SES_ACTIVE) begin
			if (p_digits == 0)
				p_rec = puk;
			code = p_rec ? cfg_recovery : cfg_user;
			want = (p_digits < CODE_NIBBLES) ? code[4*p_digits +: 4] : 4'd0;
			if (key != want)
				p_miss = 1'b1;
			p_digits++;
			if (p_digits < CODE_DIGITS) begin
				r.st = ST_DIGIT;
			end else begin
				if (p_rec) begin
					if (p_miss) begin
						r.st = ST_WRONG_REC;
					end else begin
						r.st = ST_RECOVERED;
						p_outcome = SES_OPEN;
					end
				end else if (p_miss) begin
					if (p_wrong < TRIES_SAT)
						p_wrong++;
					if (p_wrong >= cfg_max) begin
						r.st = ST_LOCKED;
						p_outcome = SES_LOCKED;
					end else begin
						r.st = ST_RETRY;
					end
				end else begin
					r.st = ST_UNLOCKED;
					p_outcome = SES_OPEN;
				end
				p_digits = '0;
				p_miss = 1'b0;
			end
		end else if (req == REQ_TIMEOUT && p_outcome == SES_ACTIVE) begin
			// with no digits yet the timeout word itself says which mode
			if (!((p_digits != 0) ? p_rec : puk)) begin
				p_digits = '0;
				p_miss = 1'b0;
				p_outcome = SES_TIMEOUT;
				r.st = ST_TIMEOUT;
			end
		end
		r.digits = p_digits;
		r.tries = (p_wrong >= cfg_max) ? 4'd0 : cfg_max - p_wrong;
		r.door = (p_outcome == SES_OPEN);
		r.lockd = (p_outcome == SES_LOCKED);
		return r;
	endfunction

	task automatic send_word(input logic [1:0] req, input logic [3:0] key, input logic puk,
			input bit typed, input lock_result_t typed_res);
		int           gap;
		lock_result_t res;
		gap = in_calm ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			in_valid <= 1'b0;
			req_type <= 2'($urandom);
			key_code <= 4'($urandom);
			puk_mode <= 1'($urandom);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		key_code <= key;
		puk_mode <= puk;
		do @(posedge clk); while (in_stall);
		res = lock_predict(req, key, puk);
		pending.push_back(typed ? typed_res : res);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending.size() != 0);
	endtask

	task automatic load_config(input logic [23:0] user, input logic [23:0] recov,
			input logic [3:0] tries);
		logic [23:0] vals [3];
		vals = '{user, recov, {20'd0, tries}};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= 2'(i);
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		cfg_user = user;
		cfg_recovery = recov;
		cfg_max = tries;
	endtask

	// result side: random stall per word, then compare with the oldest prediction
	initial begin
		int           hold;
		lock_result_t got;
		lock_result_t want;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = out_calm ? 0 : $urandom_range(0, 17);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
			got = '{status_t'(status), digits_entered, tries_left, door_open, locked_out};
			if (pending.size() == 0) begin
				report_mismatch("result word with nothing pending");
			end else begin
				want = pending.pop_front();
				if (got.st !== want.st)
					report_mismatch($sformatf("status got %0d want %0d", got.st, want.st));
				if (got.digits !== want.digits)
					report_mismatch($sformatf("digits_entered got %0d want %0d",
						got.digits, want.digits));
				if (got.tries !== want.tries)
					report_mismatch($sformatf("tries_left got %0d want %0d",
						got.tries, want.tries));
				if (got.door !== want.door)
					report_mismatch($sformatf("door_open got %0b want %0b",
						got.door, want.door));
				if (got.lockd !== want.lockd)
					report_mismatch($sformatf("locked_out got %0b want %0b",
						got.lockd, want.lockd));
			end
		end
	end

	initial begin
		logic [23:0]  code;
		logic [3:0]   k;
		bit           rec;
		bit           bad;
		int           bad_pos;
		int           sent;
		int           pick;
		int           part;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_LOCK_CODE;
		cfg_data = '0;
		in_valid = 1'b0;
		req_type = REQ_KEY;
		key_code = '0;
		puk_mode = 1'b0;
		in_calm = 1'b0;
		out_calm = 1'b0;
		mismatches = 0;
		cfg_user = 24'h000000;
		cfg_recovery = 24'h111111;
		cfg_max = 4'd3;
		p_digits = '0;
		p_miss = 1'b0;
		p_rec = 1'b0;
		p_wrong = '0;
		p_outcome = SES_ACTIVE;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(dir_rows); i++)
			send_word(dir_rows[i].req, dir_rows[i].key, dir_rows[i].puk,
				dir_rows[i].typed, dir_rows[i].res);

		for (int ph = 0; ph < 8; ph++) begin
			drain();
			case (ph)
				0: load_config(24'hFFFFFF, 24'h000000, 4'd1);
				1: load_config(24'h000000, 24'hFFFFFF, 4'd15);
				default: load_config(24'($urandom), 24'($urandom), 4'($urandom_range(1, 15)));
			endcase
			in_calm = (ph == 2) || ($urandom_range(0, 3) == 0);
			out_calm = (ph == 2) || ($urandom_range(0, 3) == 0);
			sent = 0;
			while (sent < 165) begin
				pick = $urandom_range(0, 99);
				if (p_outcome != SES_ACTIVE && $urandom_range(0, 3) != 0) begin
					send_word(REQ_RESTART, 4'($urandom), 1'($urandom), 1'b0, '0);
					sent++;
				end else if (pick < 65) begin
					// full attempt, sometimes with one key off
					rec = ($urandom_range(0, 3) == 0);
					code = rec ? cfg_recovery : cfg_user;
					bad = ($urandom_range(0, 2) == 0);
					bad_pos = $urandom_range(0, CODE_DIGITS - 1);
					for (int i = 0; i < CODE_DIGITS; i++) begin
						k = code[4*i +: 4];
						if (bad && i == bad_pos)
							k = 4'($urandom);
						send_word(REQ_KEY, k, (i == 0) ? rec : 1'($urandom), 1'b0, '0);
						sent++;
					end
				end else if (pick < 80) begin
					// partial attempt cut by a timeout
					rec = ($urandom_range(0, 3) == 0);
					code = rec ? cfg_recovery : cfg_user;
					part = $urandom_range(0, CODE_DIGITS - 1);
					for (int i = 0; i < part; i++) begin
						send_word(REQ_KEY, code[4*i +: 4], (i == 0) ? rec : 1'($urandom),
							1'b0, '0);
						sent++;
					end
					send_word(REQ_TIMEOUT, 4'($urandom), 1'($urandom), 1'b0, '0);
					sent++;
				end else if (pick < 86) begin
					send_word(REQ_RESTART, 4'($urandom), 1'($urandom), 1'b0, '0);
					sent++;
				end else begin
					send_word(2'($urandom), 4'($urandom), 1'($urandom), 1'b0, '0);
					sent++;
				end
				if ($urandom_range(0, 60) == 0)
					drain();
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending.size() == 0) begin
			$display("keypad_code_lock verification clean");
		end else begin
			$display("keypad_code_lock verification failed");
		end
		$finish;
	end

endmodule
